[rtl/frame_route_learn_and_forward_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame route learn-and-forward block
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_ROUTE_LEARN_AND_FORWARD_TOP_MACROS_SVH
`define FRAME_ROUTE_LEARN_AND_FORWARD_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FRLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FRLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/frlf_pkg.sv]
// ----------------------------------------------------------------------------
// frlf_pkg
// Types, codes and helper functions of the frame route learn-and-forward block.
// ----------------------------------------------------------------------------
package frlf_pkg;

  localparam int NUM_CHANNELS    = 4;
  localparam int ROUTE_DEPTH_DEF = 16;
  localparam int MASK_W          = 4;
  localparam int CH_W            = 2;
  localparam int ID_W            = 8;
  localparam int MSG_W           = 24;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_SYSTEM_ID    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_COMPONENT_ID = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIG = 2'd2;
  localparam logic [1:0] STATUS_NONE    = 2'd3;

  localparam logic [MSG_W-1:0] MSG_HEARTBEAT    = 24'd0;
  localparam logic [MSG_W-1:0] MSG_RADIO_STATUS = 24'd109;
  localparam logic [MSG_W-1:0] MSG_ADSB         = 24'd246;

  typedef enum logic [1:0] {
    LOOKUP_NONE,
    LOOKUP_ALL,
    LOOKUP_FIRST
  } lookup_mode_t;

  typedef struct packed {
    logic              valid;
    logic              learn;
    logic              appended;
    logic              heartbeat;
    logic [CH_W-1:0]   ch;
    logic [ID_W-1:0]   sys;
    logic [ID_W-1:0]   comp;
    logic [ID_W-1:0]   vtype;
    lookup_mode_t      mode;
    logic [ID_W-1:0]   ts;
    logic [ID_W-1:0]   tc;
    logic              found;
    logic [MASK_W-1:0] mask;
    logic              deliver;
  } token_t;

  function automatic logic [MASK_W-1:0] chan_bit(input logic [CH_W-1:0] c);
    logic [MASK_W-1:0] b;
    for (int i = 0; i < MASK_W; i++) begin
      b[i] = (int'(c) == i) && (i < NUM_CHANNELS);
    end
    return b;
  endfunction

  function automatic logic [MASK_W-1:0] flood_mask(input logic [CH_W-1:0] c);
    logic [MASK_W-1:0] b;
    for (int i = 0; i < MASK_W; i++) begin
      b[i] = (int'(c) != i) && (i < NUM_CHANNELS);
    end
    return b;
  endfunction

endpackage

[rtl/frlf_decode.sv]
// ----------------------------------------------------------------------------
// frlf_decode
// Classifies a frame header and builds the word that walks the route cells.
// ----------------------------------------------------------------------------
module frlf_decode (
  input  logic                            valid,
  input  logic [1:0]                      framing_status,
  input  logic [frlf_pkg::CH_W-1:0]       in_channel,
  input  logic [frlf_pkg::ID_W-1:0]       src_system,
  input  logic [frlf_pkg::ID_W-1:0]       src_component,
  input  logic [frlf_pkg::MSG_W-1:0]      msg_id,
  input  logic                            msg_known,
  input  logic                            has_target_system,
  input  logic [frlf_pkg::ID_W-1:0]       target_system,
  input  logic                            has_target_component,
  input  logic [frlf_pkg::ID_W-1:0]       target_component,
  input  logic [frlf_pkg::ID_W-1:0]       heartbeat_type,
  input  logic [frlf_pkg::ID_W-1:0]       local_system_id,
  input  logic [frlf_pkg::ID_W-1:0]       local_component_id,
  output frlf_pkg::token_t                tok
);

  logic loopback;
  logic ts_ok;
  logic tc_ok;
  logic frame_ok;

  assign loopback = (src_system == local_system_id) && (src_component == local_component_id);
  assign ts_ok    = msg_known && has_target_system;
  assign tc_ok    = msg_known && has_target_component;
  assign frame_ok = (framing_status == frlf_pkg::STATUS_OK) && !loopback;

  always_comb begin
    tok           = '0;
    tok.valid     = valid;
    tok.ch        = in_channel;
    tok.sys       = src_system;
    tok.comp      = src_component;
    tok.vtype     = heartbeat_type;
    tok.heartbeat = (msg_id == frlf_pkg::MSG_HEARTBEAT);
    tok.ts        = target_system;
    tok.tc        = target_component;
    tok.mode      = frlf_pkg::LOOKUP_NONE;
    tok.learn     = frame_ok && (src_system != '0) &&
                    !((src_system == local_system_id) && (src_component == '0));
    if ((framing_status == frlf_pkg::STATUS_BAD_CRC) ||
        (framing_status == frlf_pkg::STATUS_BAD_SIG)) begin
      tok.mask = frlf_pkg::flood_mask(in_channel);
    end else if (frame_ok) begin
      if ((msg_id == frlf_pkg::MSG_RADIO_STATUS) || (msg_id == frlf_pkg::MSG_ADSB)) begin
        tok.deliver = 1'b1;
      end else begin
        tok.deliver = msg_known;
        if (ts_ok && (target_system == local_system_id)) begin
          if (tc_ok && (target_component == local_component_id)) begin
            tok.mode = frlf_pkg::LOOKUP_NONE;
          end else if (!tc_ok || (target_component == '0)) begin
            tok.mode = frlf_pkg::LOOKUP_ALL;
          end else begin
            tok.mode = frlf_pkg::LOOKUP_FIRST;
          end
        end else begin
          tok.mask = frlf_pkg::flood_mask(in_channel);
        end
      end
    end
  end

endmodule

[rtl/frlf_cell.sv]
// ----------------------------------------------------------------------------
// frlf_cell
// One route table entry that learns from and answers the passing word.
// ----------------------------------------------------------------------------
module frlf_cell #(
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  frlf_pkg::token_t tok_in,
  input  logic [CNT_W-1:0] rem_in,
  output frlf_pkg::token_t tok_out,
  output logic [CNT_W-1:0] rem_out
);

  logic [frlf_pkg::CH_W-1:0] e_ch;
  logic [frlf_pkg::ID_W-1:0] e_sys;
  logic [frlf_pkg::ID_W-1:0] e_comp;
  logic [frlf_pkg::ID_W-1:0] e_vtype;

  logic                      live;
  logic                      hit;
  logic                      append;
  logic                      present;
  logic [frlf_pkg::CH_W-1:0] p_ch;
  logic [frlf_pkg::ID_W-1:0] p_sys;
  logic [frlf_pkg::ID_W-1:0] p_comp;
  frlf_pkg::token_t          tok_next;

  assign live    = (rem_in != '0);
  assign hit     = live && tok_in.learn && (e_ch == tok_in.ch) &&
                   (e_sys == tok_in.sys) && (e_comp == tok_in.comp);
  assign append  = !live && tok_in.learn;
  assign present = live || append;
  assign p_ch    = append ? tok_in.ch : e_ch;
  assign p_sys   = append ? tok_in.sys : e_sys;
  assign p_comp  = append ? tok_in.comp : e_comp;

  always_comb begin
    tok_next          = tok_in;
    tok_next.learn    = tok_in.learn && !hit && !append;
    tok_next.appended = tok_in.appended || append;
    if ((tok_in.mode == frlf_pkg::LOOKUP_ALL) && present && (p_sys == tok_in.ts)) begin
      tok_next.mask = tok_in.mask | frlf_pkg::chan_bit(p_ch);
    end else if ((tok_in.mode == frlf_pkg::LOOKUP_FIRST) && present && !tok_in.found &&
                 (p_sys == tok_in.ts) && (p_comp == tok_in.tc)) begin
      tok_next.mask    = tok_in.mask | frlf_pkg::chan_bit(p_ch);
      tok_next.found   = 1'b1;
      tok_next.deliver = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      if (append) begin
        e_ch    <= tok_in.ch;
        e_sys   <= tok_in.sys;
        e_comp  <= tok_in.comp;
        e_vtype <= tok_in.heartbeat ? tok_in.vtype : '0;
      end else if (hit && (e_vtype == '0) && tok_in.heartbeat) begin
        e_vtype <= tok_in.vtype;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.learn     <= tok_next.learn;
    tok_out.appended  <= tok_next.appended;
    tok_out.heartbeat <= tok_next.heartbeat;
    tok_out.ch        <= tok_next.ch;
    tok_out.sys       <= tok_next.sys;
    tok_out.comp      <= tok_next.comp;
    tok_out.vtype     <= tok_next.vtype;
    tok_out.mode      <= tok_next.mode;
    tok_out.ts        <= tok_next.ts;
    tok_out.tc        <= tok_next.tc;
    tok_out.found     <= tok_next.found;
    tok_out.mask      <= tok_next.mask;
    tok_out.deliver   <= tok_next.deliver;
    rem_out           <= live ? rem_in - CNT_W'(1) : '0;
  end

endmodule

[rtl/frame_route_learn_and_forward_top.sv]
// ----------------------------------------------------------------------------
// frame_route_learn_and_forward_top
// Learns routes from frame headers and returns one forwarding word per frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Word
// in        input      in_valid/in_ready   frame header fields
// out       output     out_valid/out_ready forward_mask, deliver_local
// cfg       input      cfg_write_en        cfg_index, cfg_data
//
// The next frame is accepted only once the previous result word has moved from
// the holding register into the output register.
// The header walks the row of route cells one cell per cycle, then passes a
// holding register into the output register. One frame is in work at a time.
// Reset clears the route count, so the table starts empty.
// A stalled output holds its word while the next frame is already accepted.
// ----------------------------------------------------------------------------
module frame_route_learn_and_forward_top #(
  parameter int ROUTE_DEPTH = frlf_pkg::ROUTE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [frlf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [frlf_pkg::ID_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          framing_status,
  input  logic [frlf_pkg::CH_W-1:0]           in_channel,
  input  logic [frlf_pkg::ID_W-1:0]           src_system,
  input  logic [frlf_pkg::ID_W-1:0]           src_component,
  input  logic [frlf_pkg::MSG_W-1:0]          msg_id,
  input  logic                                msg_known,
  input  logic                                has_target_system,
  input  logic [frlf_pkg::ID_W-1:0]           target_system,
  input  logic                                has_target_component,
  input  logic [frlf_pkg::ID_W-1:0]           target_component,
  input  logic [frlf_pkg::ID_W-1:0]           heartbeat_type,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [frlf_pkg::MASK_W-1:0]         forward_mask,
  output logic                                deliver_local
);

  localparam int CNT_W = $clog2(ROUTE_DEPTH + 1);

  logic [frlf_pkg::ID_W-1:0]   local_system_id;
  logic [frlf_pkg::ID_W-1:0]   local_component_id;
  logic [CNT_W-1:0]            route_count;
  logic                        busy;
  logic                        pend_valid;
  logic [frlf_pkg::MASK_W-1:0] pend_mask;
  logic                        pend_deliver;
  logic                        in_accept;
  logic                        pend_move;

  frlf_pkg::token_t tok [ROUTE_DEPTH+1];
  logic [CNT_W-1:0] rem [ROUTE_DEPTH+1];

  assign in_ready  = !busy;
  assign in_accept = in_valid && !busy;
  assign pend_move = pend_valid && (!out_valid || out_ready);
  assign rem[0]    = route_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_system_id    <= '0;
      local_component_id <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        frlf_pkg::CFG_LOCAL_SYSTEM_ID:    local_system_id    <= cfg_data;
        frlf_pkg::CFG_LOCAL_COMPONENT_ID: local_component_id <= cfg_data;
        default:                          local_system_id    <= local_system_id;
      endcase
    end
  end

  frlf_decode u_decode (
    .valid                (in_accept),
    .framing_status       (framing_status),
    .in_channel           (in_channel),
    .src_system           (src_system),
    .src_component        (src_component),
    .msg_id               (msg_id),
    .msg_known            (msg_known),
    .has_target_system    (has_target_system),
    .target_system        (target_system),
    .has_target_component (has_target_component),
    .target_component     (target_component),
    .heartbeat_type       (heartbeat_type),
    .local_system_id      (local_system_id),
    .local_component_id   (local_component_id),
    .tok                  (tok[0])
  );

  for (genvar k = 0; k < ROUTE_DEPTH; k++) begin : g_cell
    frlf_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .rem_in  (rem[k]),
      .tok_out (tok[k+1]),
      .rem_out (rem[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      route_count <= '0;
    end else begin
      if (in_accept) begin
        busy <= 1'b1;
      end
      if (tok[ROUTE_DEPTH].valid) begin
        pend_valid <= 1'b1;
        if (tok[ROUTE_DEPTH].appended) begin
          route_count <= route_count + CNT_W'(1);
        end
      end else if (pend_move) begin
        pend_valid <= 1'b0;
        busy       <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[ROUTE_DEPTH].valid) begin
      pend_mask    <= tok[ROUTE_DEPTH].mask;
      pend_deliver <= tok[ROUTE_DEPTH].deliver;
    end
    if (pend_move) begin
      forward_mask  <= pend_mask;
      deliver_local <= pend_deliver;
    end
  end

endmodule

[rtl/frlf_checker.sv]
// ----------------------------------------------------------------------------
// frlf_checker
// Port-level checks on the frame route learn-and-forward block.
// ----------------------------------------------------------------------------
`include "frame_route_learn_and_forward_top_macros.svh"

module frlf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [frlf_pkg::MASK_W-1:0] forward_mask,
  input logic                        deliver_local
);

  `FRLF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(forward_mask) && $stable(deliver_local), "Stalled output word changed.")
  `FRLF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "Input ready right after a word was accepted.")
  `FRLF_ASSERT_NOW(a_busy_walk, in_valid && in_ready, ##2 !in_ready, "Input ready before the route walk finished.")
  `FRLF_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(!in_ready), "Result word appeared with no frame in work.")

endmodule

bind frame_route_learn_and_forward_top frlf_checker u_frlf_checker (.*);

[tb/frame_route_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame route checker
// Watches the register port and both word channels of the route block. It
// keeps its own route table and local address, works out the forwarding
// word for every accepted header, and compares every output word with the
// oldest expected word. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module frame_route_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [frlf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frlf_pkg::ID_W-1:0]      cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     framing_status,
  input  logic [frlf_pkg::CH_W-1:0]      in_channel,
  input  logic [frlf_pkg::ID_W-1:0]      src_system,
  input  logic [frlf_pkg::ID_W-1:0]      src_component,
  input  logic [frlf_pkg::MSG_W-1:0]     msg_id,
  input  logic                           msg_known,
  input  logic                           has_target_system,
  input  logic [frlf_pkg::ID_W-1:0]      target_system,
  input  logic                           has_target_component,
  input  logic [frlf_pkg::ID_W-1:0]      target_component,
  input  logic [frlf_pkg::ID_W-1:0]      heartbeat_type,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [frlf_pkg::MASK_W-1:0]    forward_mask,
  input  logic                           deliver_local,
  output int                             fail_count,
  output int                             words_pending
);

  localparam logic [frlf_pkg::MASK_W-1:0] ALL_CHANNELS =
    frlf_pkg::MASK_W'((1 << frlf_pkg::NUM_CHANNELS) - 1);

  typedef struct packed {
    logic [frlf_pkg::MASK_W-1:0] mask;
    logic                        deliver;
  } decision_t;

  logic [frlf_pkg::CH_W-1:0] route_ch    [frlf_pkg::ROUTE_DEPTH_DEF];
  logic [frlf_pkg::ID_W-1:0] route_sys   [frlf_pkg::ROUTE_DEPTH_DEF];
  logic [frlf_pkg::ID_W-1:0] route_comp  [frlf_pkg::ROUTE_DEPTH_DEF];
  logic [frlf_pkg::ID_W-1:0] route_vtype [frlf_pkg::ROUTE_DEPTH_DEF];
  int                        route_fill;
  logic [frlf_pkg::ID_W-1:0] local_sys;
  logic [frlf_pkg::ID_W-1:0] local_comp;
  decision_t                 decision_q [$];

  initial begin
    fail_count    = 0;
    words_pending = 0;
  end

  function automatic logic [frlf_pkg::MASK_W-1:0] port_bit(
      input logic [frlf_pkg::CH_W-1:0] c);
    port_bit = (int'(c) < frlf_pkg::NUM_CHANNELS) ? (frlf_pkg::MASK_W'(1) << c) : '0;
  endfunction

  function automatic void learn_route(input logic [frlf_pkg::CH_W-1:0] ch,
                                      input logic [frlf_pkg::ID_W-1:0] sys, comp,
                                      input logic is_hb,
                                      input logic [frlf_pkg::ID_W-1:0] vtype);
    logic hit;
    hit = 1'b0;
    if (sys != 0 && !(sys == local_sys && comp == 0)) begin
      for (int k = 0; k < route_fill; k++) begin
        if (!hit && route_ch[k] == ch && route_sys[k] == sys && route_comp[k] == comp) begin
          hit = 1'b1;
          if (route_vtype[k] == 0 && is_hb)
            route_vtype[k] = vtype;
        end
      end
      if (!hit && route_fill < frlf_pkg::ROUTE_DEPTH_DEF) begin
        route_ch[route_fill]    = ch;
        route_sys[route_fill]   = sys;
        route_comp[route_fill]  = comp;
        route_vtype[route_fill] = is_hb ? vtype : '0;
        route_fill++;
      end
    end
  endfunction

  function automatic decision_t route_decision(input logic [1:0] status,
                                               input logic [frlf_pkg::CH_W-1:0] ch,
                                               input logic [frlf_pkg::ID_W-1:0] sys, comp,
                                               input logic [frlf_pkg::MSG_W-1:0] id,
                                               input logic known, has_ts,
                                               input logic [frlf_pkg::ID_W-1:0] ts,
                                               input logic has_tc,
                                               input logic [frlf_pkg::ID_W-1:0] tc, vtype);
    decision_t d;
    logic [frlf_pkg::MASK_W-1:0] flood;
    logic tc_ok;
    logic hit;
    d = '0;
    hit = 1'b0;
    flood = ALL_CHANNELS & ~port_bit(ch);
    tc_ok = known && has_tc;
    if (status == frlf_pkg::STATUS_BAD_CRC || status == frlf_pkg::STATUS_BAD_SIG) begin
      d.mask = flood;
    end else if (status == frlf_pkg::STATUS_OK &&
                 !(sys == local_sys && comp == local_comp)) begin
      learn_route(ch, sys, comp, id == frlf_pkg::MSG_HEARTBEAT, vtype);
      d.deliver = 1'b1;
      if (id != frlf_pkg::MSG_RADIO_STATUS && id != frlf_pkg::MSG_ADSB) begin
        d.deliver = known;
        if (known && has_ts && ts == local_sys) begin
          if (tc_ok && tc == local_comp) begin
            d.mask = '0;
          end else if (!tc_ok || tc == 0) begin
            for (int k = 0; k < route_fill; k++)
              if (route_sys[k] == ts)
                d.mask |= port_bit(route_ch[k]);
          end else begin
            for (int k = 0; k < route_fill; k++) begin
              if (!hit && route_sys[k] == ts && route_comp[k] == tc) begin
                hit = 1'b1;
                d.deliver = 1'b0;
                d.mask = port_bit(route_ch[k]);
              end
            end
          end
        end else begin
          d.mask = flood;
        end
      end
    end
    return d;
  endfunction

  always @(posedge clk) begin
    decision_t got;
    decision_t want;
    if (rst) begin
      decision_q.delete();
      route_fill = 0;
      local_sys  = '0;
      local_comp = '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          frlf_pkg::CFG_LOCAL_SYSTEM_ID:    local_sys  = cfg_data;
          frlf_pkg::CFG_LOCAL_COMPONENT_ID: local_comp = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.mask    = forward_mask;
        got.deliver = deliver_local;
        if (decision_q.size() == 0) begin
          $display("%0t ns: word with none expected, mask %h deliver %b",
                   $time, got.mask, got.deliver);
          fail_count++;
        end else begin
          want = decision_q.pop_front();
          if (got.mask !== want.mask) begin
            $display("%0t ns: forward_mask expected %h actual %h",
                     $time, want.mask, got.mask);
            fail_count++;
          end
          if (got.deliver !== want.deliver) begin
            $display("%0t ns: deliver_local expected %b actual %b",
                     $time, want.deliver, got.deliver);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decision_q.push_back(route_decision(framing_status, in_channel, src_system,
                                            src_component, msg_id, msg_known,
                                            has_target_system, target_system,
                                            has_target_component, target_component,
                                            heartbeat_type));
      end
    end
    words_pending = decision_q.size();
  end

endmodule

[tb/frame_route_learn_and_forward_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame route learn-and-forward testbench
// Drives frame headers into the route block under several local addresses,
// starting with directed headers for each forwarding rule and then random
// headers drawn from a small address pool so that routes are learned, hit
// and the table fills. Both channels idle at random, and the output is held
// off for a long stretch once. The checker reports the failure count.
// ----------------------------------------------------------------------------
module frame_route_learn_and_forward_top_tb;

  typedef struct packed {
    logic [1:0]                 status;
    logic [frlf_pkg::CH_W-1:0]  ch;
    logic [frlf_pkg::ID_W-1:0]  sys;
    logic [frlf_pkg::ID_W-1:0]  comp;
    logic [frlf_pkg::MSG_W-1:0] id;
    logic                       known;
    logic                       has_ts;
    logic [frlf_pkg::ID_W-1:0]  ts;
    logic                       has_tc;
    logic [frlf_pkg::ID_W-1:0]  tc;
    logic [frlf_pkg::ID_W-1:0]  vtype;
  } frame_hdr_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write_en;
  logic [frlf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [frlf_pkg::ID_W-1:0]      cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     framing_status;
  logic [frlf_pkg::CH_W-1:0]      in_channel;
  logic [frlf_pkg::ID_W-1:0]      src_system;
  logic [frlf_pkg::ID_W-1:0]      src_component;
  logic [frlf_pkg::MSG_W-1:0]     msg_id;
  logic                           msg_known;
  logic                           has_target_system;
  logic [frlf_pkg::ID_W-1:0]      target_system;
  logic                           has_target_component;
  logic [frlf_pkg::ID_W-1:0]      target_component;
  logic [frlf_pkg::ID_W-1:0]      heartbeat_type;
  logic                           out_valid;
  logic                           out_ready;
  logic [frlf_pkg::MASK_W-1:0]    forward_mask;
  logic                           deliver_local;
  int                             fail_count;
  int                             words_pending;

  logic [frlf_pkg::ID_W-1:0]      cur_sys;
  logic [frlf_pkg::ID_W-1:0]      cur_comp;
  logic                           steady;

  frame_route_learn_and_forward_top dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .framing_status(framing_status), .in_channel(in_channel),
    .src_system(src_system), .src_component(src_component),
    .msg_id(msg_id), .msg_known(msg_known),
    .has_target_system(has_target_system), .target_system(target_system),
    .has_target_component(has_target_component), .target_component(target_component),
    .heartbeat_type(heartbeat_type),
    .out_valid(out_valid), .out_ready(out_ready),
    .forward_mask(forward_mask), .deliver_local(deliver_local)
  );

  frame_route_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .framing_status(framing_status), .in_channel(in_channel),
    .src_system(src_system), .src_component(src_component),
    .msg_id(msg_id), .msg_known(msg_known),
    .has_target_system(has_target_system), .target_system(target_system),
    .has_target_component(has_target_component), .target_component(target_component),
    .heartbeat_type(heartbeat_type),
    .out_valid(out_valid), .out_ready(out_ready),
    .forward_mask(forward_mask), .deliver_local(deliver_local),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #7_200_000;
    $display("*** FAILED ***");
    $finish;
  end

  // The receiver holds off for a long stretch once while headers keep coming.
  initial begin
    int cyc;
    cyc = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst)
        cyc++;
      if (cyc >= 2000 && cyc < 2400)
        out_ready <= 1'b0;
      else if (steady)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(99) >= 36);
    end
  end

  function automatic frame_hdr_t make_hdr(input logic [1:0] status,
                                          input logic [frlf_pkg::CH_W-1:0] ch,
                                          input logic [frlf_pkg::ID_W-1:0] sys, comp,
                                          input logic [frlf_pkg::MSG_W-1:0] id,
                                          input logic known, has_ts,
                                          input logic [frlf_pkg::ID_W-1:0] ts,
                                          input logic has_tc,
                                          input logic [frlf_pkg::ID_W-1:0] tc, vtype);
    frame_hdr_t f;
    f.status = status;
    f.ch     = ch;
    f.sys    = sys;
    f.comp   = comp;
    f.id     = id;
    f.known  = known;
    f.has_ts = has_ts;
    f.ts     = ts;
    f.has_tc = has_tc;
    f.tc     = tc;
    f.vtype  = vtype;
    return f;
  endfunction

  function automatic frame_hdr_t random_hdr();
    frame_hdr_t f;
    int pick;
    f.status = ($urandom_range(99) < 82) ? frlf_pkg::STATUS_OK : 2'($urandom_range(1, 3));
    f.ch = frlf_pkg::CH_W'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 10)      f.sys = cur_sys;
    else if (pick < 18) f.sys = '0;
    else if (pick < 80) f.sys = frlf_pkg::ID_W'($urandom_range(1, 4));
    else                f.sys = frlf_pkg::ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 15)      f.comp = cur_comp;
    else if (pick < 65) f.comp = frlf_pkg::ID_W'($urandom_range(0, 3));
    else                f.comp = frlf_pkg::ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 30)      f.id = frlf_pkg::MSG_HEARTBEAT;
    else if (pick < 40) f.id = frlf_pkg::MSG_RADIO_STATUS;
    else if (pick < 50) f.id = frlf_pkg::MSG_ADSB;
    else if (pick < 80) f.id = frlf_pkg::MSG_W'($urandom_range(1, 300));
    else                f.id = frlf_pkg::MSG_W'($urandom);
    f.known  = ($urandom_range(99) < 85);
    f.has_ts = ($urandom_range(99) < 70);
    pick = $urandom_range(99);
    if (pick < 60)      f.ts = cur_sys;
    else if (pick < 80) f.ts = frlf_pkg::ID_W'($urandom_range(1, 4));
    else                f.ts = frlf_pkg::ID_W'($urandom);
    f.has_tc = ($urandom_range(99) < 60);
    pick = $urandom_range(99);
    if (pick < 30)      f.tc = cur_comp;
    else if (pick < 50) f.tc = '0;
    else if (pick < 80) f.tc = frlf_pkg::ID_W'($urandom_range(0, 3));
    else                f.tc = frlf_pkg::ID_W'($urandom);
    f.vtype = ($urandom_range(99) < 50) ? '0 : frlf_pkg::ID_W'($urandom);
    return f;
  endfunction

  task automatic push_frame(input frame_hdr_t f);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid             <= 1'b1;
    framing_status       <= f.status;
    in_channel           <= f.ch;
    src_system           <= f.sys;
    src_component        <= f.comp;
    msg_id               <= f.id;
    msg_known            <= f.known;
    has_target_system    <= f.has_ts;
    target_system        <= f.ts;
    has_target_component <= f.has_tc;
    target_component     <= f.tc;
    heartbeat_type       <= f.vtype;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [frlf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frlf_pkg::ID_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do
      @(negedge clk);
    while (words_pending != 0);
  endtask

  task automatic set_local(input logic [frlf_pkg::ID_W-1:0] sys, comp);
    settle();
    write_reg(frlf_pkg::CFG_LOCAL_SYSTEM_ID, sys);
    write_reg(frlf_pkg::CFG_LOCAL_COMPONENT_ID, comp);
    cur_sys  = sys;
    cur_comp = comp;
  endtask

  task automatic random_phase(input logic [frlf_pkg::ID_W-1:0] sys, comp,
                              input int count, input logic calm);
    set_local(sys, comp);
    steady = calm;
    repeat (count)
      push_frame(random_hdr());
    steady = 1'b0;
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_write_en         = 1'b0;
    cfg_index            = frlf_pkg::CFG_LOCAL_SYSTEM_ID;
    cfg_data             = '0;
    in_valid             = 1'b0;
    framing_status       = frlf_pkg::STATUS_NONE;
    in_channel           = '0;
    src_system           = '0;
    src_component        = '0;
    msg_id               = '0;
    msg_known            = 1'b0;
    has_target_system    = 1'b0;
    target_system        = '0;
    has_target_component = 1'b0;
    target_component     = '0;
    heartbeat_type       = '0;
    cur_sys              = '0;
    cur_comp             = '0;
    steady               = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Local address still at its reset value of zero.
    push_frame(make_hdr(frlf_pkg::STATUS_NONE, 2, 7, 7, 5, 1, 1, 0, 1, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_BAD_CRC, 0, 1, 1, frlf_pkg::MSG_HEARTBEAT,
                        1, 0, 0, 0, 0, 3));
    push_frame(make_hdr(frlf_pkg::STATUS_BAD_SIG, 3, 1, 1, 5, 1, 1, 0, 1, 0, 3));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 1, 0, 0, 5, 1, 0, 0, 0, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 1, 0, 5, frlf_pkg::MSG_HEARTBEAT,
                        1, 0, 0, 0, 0, 9));

    set_local(10, 20);
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 2, 1, 1, frlf_pkg::MSG_HEARTBEAT,
                        1, 0, 0, 0, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 2, 1, 1, frlf_pkg::MSG_HEARTBEAT,
                        1, 0, 0, 0, 0, 7));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 1, 10, 0, 5, 1, 0, 0, 0, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 1, 10, 3, 5, 1, 0, 0, 0, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 3, 10, 3, 5, 1, 0, 0, 0, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 1, 10, 1, 20, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 1, 10, 0, 20, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 1, 10, 1, 0, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 1, 10, 1, 3, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 1, 10, 1, 99, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 1, 11, 1, 3, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 1, 0, 10, 1, 3, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, 5, 0, 1, 10, 1, 3, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 0, 2, 10, frlf_pkg::MSG_RADIO_STATUS,
                        1, 1, 10, 1, 3, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 2, 10, 20, 5, 1, 1, 10, 1, 3, 0));
    push_frame(make_hdr(frlf_pkg::STATUS_OK, 3, 255, 255, 24'hFFFFFF,
                        1, 1, 255, 1, 255, 255));

    random_phase(2, 1, 100, 1'b0);
    random_phase(255, 255, 100, 1'b1);
    random_phase(0, 255, 100, 1'b0);
    random_phase(255, 0, 100, 1'b0);
    random_phase(3, frlf_pkg::ID_W'($urandom), 100, 1'b0);

    settle();
    repeat (frlf_pkg::ROUTE_DEPTH_DEF + 4) @(negedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[frame_route_learn_and_forward_top.f]
+incdir+rtl
rtl/frlf_pkg.sv
rtl/frlf_decode.sv
rtl/frlf_cell.sv
rtl/frame_route_learn_and_forward_top.sv
rtl/frlf_checker.sv
tb/frame_route_checker.sv
tb/frame_route_learn_and_forward_top_tb.sv
